// ===== hdl/shortest_job_hold_queue_core_assert.svh =====
// Assertion macros for the shortest job hold queue.
// Taken in by the RTL files that carry concurrent assertions.
`ifndef SHORTEST_JOB_HOLD_QUEUE_CORE_ASSERT_SVH
`define SHORTEST_JOB_HOLD_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SJHQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define SJHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sjhq_pkg.sv =====
// Shared types and constants for the shortest job hold queue.
// No dependencies; the RTL and bench files use it by scoped names.
package sjhq_pkg;

   localparam int ID_W     = 16;
   localparam int KEY_W    = 16;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic {
      MODE_FIFO   = 1'b0,
      MODE_SORTED = 1'b1
   } mode_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic      ins;
      logic      rem;
      logic      sorted;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// ===== hdl/sjhq_ifs.sv =====
// Valid/ready channel interfaces for the shortest job hold queue.
// Depends on sjhq_pkg for field widths.
interface sjhq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [sjhq_pkg::ID_W-1:0]     job_id;
   logic [sjhq_pkg::KEY_W-1:0]    sort_key;

   modport source (output valid, op, job_id, sort_key, input ready);
   modport sink   (input valid, op, job_id, sort_key, output ready);
endinterface

interface sjhq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sjhq_pkg::STATUS_W-1:0] status;
   logic                          removed_valid;
   logic [sjhq_pkg::ID_W-1:0]     removed_job_id;
   logic [sjhq_pkg::KEY_W-1:0]    removed_key;
   logic                          is_empty;
   logic                          is_full;
   logic [sjhq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, status, removed_valid, removed_job_id, removed_key,
                   is_empty, is_full, occupancy, input ready);
   modport sink   (input valid, status, removed_valid, removed_job_id, removed_key,
                   is_empty, is_full, occupancy, output ready);
endinterface

// ===== hdl/sjhq_cell.sv =====
// One slot of the hold queue chain: holds a job, compares against the new job.
// Depends on sjhq_pkg.
module sjhq_cell (
   input  logic                    clock,
   input  sjhq_pkg::cell_ctrl_type ctrl,
   input  logic                    cell_valid,
   input  sjhq_pkg::entry_type     left_entry,
   input  sjhq_pkg::entry_type     right_entry,
   input  logic                    ahead_in,
   output logic                    ahead_out,
   output sjhq_pkg::entry_type     entry
);

   sjhq_pkg::entry_type entry_ff;
   sjhq_pkg::entry_type entry_in;
   logic                stays_ahead;

   // In FIFO mode every held job stays ahead of the new one.
   assign stays_ahead = cell_valid &&
                        (!ctrl.sorted || (entry_ff.key < ctrl.new_entry.key));
   assign ahead_out   = ahead_in && stays_ahead;
   assign entry       = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rem) begin
         entry_in = right_entry;
      end else if (ctrl.ins) begin
         if (!ahead_in) begin
            entry_in = left_entry;
         end else if (!stays_ahead) begin
            entry_in = ctrl.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/shortest_job_hold_queue_core.sv =====
// Shortest job hold queue: a chain of compare-and-shift cells plus control.
// Depends on sjhq_pkg, sjhq_ifs, sjhq_cell and the assertion macro header.
//
// Usage:
//   req_ch carries one item per handshake: op (insert or remove head), job_id
//   and sort_key. rsp_ch returns exactly one result per item: status, the
//   removed job (if any), empty/full flags and the occupancy after the item.
//   csr_wr_en/csr_wr_data write the order mode (1 sorted by key, 0 FIFO);
//   write it only while no item is outstanding.
//   The result is valid in the cycle after the item is accepted.
//   Throughput: one item per cycle while the receiver takes each result; every
//   cell compares and shifts in the same cycle, so the speed is set by the
//   ahead-flag chain that ripples through the QUEUE_DEPTH cells.
//   A result waits in the output register; req_ch.ready stays high while
//   that register is empty or being drained, so a stalled receiver holds
//   the result and blocks only the next item.
//   Reset empties the queue, selects sorted mode and drops any pending
//   result. Entry contents are not cleared; only the held count matters.
`include "shortest_job_hold_queue_core_assert.svh"

module shortest_job_hold_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   sjhq_req_if.sink          req_ch,
   sjhq_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                    mode_ff, mode_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    accept;
   logic                    is_remove;
   logic                    q_full, q_empty;
   sjhq_pkg::cell_ctrl_type ctrl;
   logic                    ahead [QUEUE_DEPTH+1];
   sjhq_pkg::entry_type     cells [QUEUE_DEPTH];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sjhq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_removed_valid_ff, rsp_removed_valid_in;
   logic [sjhq_pkg::ID_W-1:0]     rsp_removed_id_ff, rsp_removed_id_in;
   logic [sjhq_pkg::KEY_W-1:0]    rsp_removed_key_ff, rsp_removed_key_in;
   logic                          rsp_is_empty_ff, rsp_is_empty_in;
   logic                          rsp_is_full_ff, rsp_is_full_in;
   logic [sjhq_pkg::OCC_W-1:0]    rsp_occupancy_ff, rsp_occupancy_in;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_remove    = (req_ch.op == sjhq_pkg::OP_REMOVE);
   assign q_full       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign q_empty      = (count_ff == '0);

   assign ctrl.ins              = accept && !is_remove && !q_full;
   assign ctrl.rem              = accept && is_remove && !q_empty;
   assign ctrl.sorted           = (mode_ff == sjhq_pkg::MODE_SORTED);
   assign ctrl.new_entry.id     = req_ch.job_id;
   assign ctrl.new_entry.key    = req_ch.sort_key;

   assign ahead[0] = 1'b1;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sjhq_pkg::entry_type left_e, right_e;
      logic                valid_c;

      assign valid_c = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_head
         assign left_e = ctrl.new_entry;
      end else begin : g_mid_l
         assign left_e = cells[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = cells[i];
      end else begin : g_mid_r
         assign right_e = cells[i+1];
      end

      sjhq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_valid  (valid_c),
         .left_entry  (left_e),
         .right_entry (right_e),
         .ahead_in    (ahead[i]),
         .ahead_out   (ahead[i+1]),
         .entry       (cells[i])
      );
   end

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_status_in        = sjhq_pkg::STATUS_DONE;
      rsp_removed_valid_in = 1'b0;
      rsp_removed_id_in    = '0;
      rsp_removed_key_in   = '0;
      if (is_remove) begin
         if (q_empty) begin
            rsp_status_in = sjhq_pkg::STATUS_EMPTY;
         end else begin
            rsp_removed_valid_in = 1'b1;
            rsp_removed_id_in    = cells[0].id;
            rsp_removed_key_in   = cells[0].key;
         end
      end else if (q_full) begin
         rsp_status_in = sjhq_pkg::STATUS_FULL;
      end
      rsp_is_empty_in  = (count_in == '0);
      rsp_is_full_in   = (count_in == COUNT_W'(QUEUE_DEPTH));
      rsp_occupancy_in = sjhq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sjhq_pkg::MODE_SORTED;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until the next item is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff        <= rsp_status_in;
         rsp_removed_valid_ff <= rsp_removed_valid_in;
         rsp_removed_id_ff    <= rsp_removed_id_in;
         rsp_removed_key_ff   <= rsp_removed_key_in;
         rsp_is_empty_ff      <= rsp_is_empty_in;
         rsp_is_full_ff       <= rsp_is_full_in;
         rsp_occupancy_ff     <= rsp_occupancy_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.removed_valid  = rsp_removed_valid_ff;
   assign rsp_ch.removed_job_id = rsp_removed_id_ff;
   assign rsp_ch.removed_key    = rsp_removed_key_ff;
   assign rsp_ch.is_empty       = rsp_is_empty_ff;
   assign rsp_ch.is_full        = rsp_is_full_ff;
   assign rsp_ch.occupancy      = rsp_occupancy_ff;

   `SJHQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= COUNT_W'(QUEUE_DEPTH), "held count exceeds queue depth")

   `SJHQ_ASSERT_NEXT(a_remove_count, clock, reset, ctrl.rem,
      count_ff == COUNT_W'($past(count_ff) - COUNT_W'(1)),
      "remove did not drop the held count by one")

   `SJHQ_ASSERT_NEXT(a_insert_done, clock, reset, ctrl.ins,
      rsp_valid_ff && (rsp_status_ff == sjhq_pkg::STATUS_DONE) && !rsp_is_empty_ff,
      "accepted insert did not report done on a non-empty queue")

   `SJHQ_ASSERT_SAME(a_removed_not_full, clock, reset,
      rsp_valid_ff && rsp_removed_valid_ff,
      !rsp_is_full_ff && (rsp_status_ff == sjhq_pkg::STATUS_DONE),
      "removed job reported with full queue or error status")

endmodule

// ===== bench/shortest_job_hold_queue_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for shortest_job_hold_queue_core: a directed table, then random phases.
// Needs sjhq_pkg, the sjhq_ifs channel interfaces and the core RTL.
module shortest_job_hold_queue_core_test;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam int LONG_HOLD    = 80;
   localparam int STALL_LIMIT  = 2000;
   localparam int ID_W         = sjhq_pkg::ID_W;
   localparam int KEY_W        = sjhq_pkg::KEY_W;
   localparam int OCC_W        = sjhq_pkg::OCC_W;

   typedef struct packed {
      sjhq_pkg::status_type status;
      logic                 removed_valid;
      logic [ID_W-1:0]      removed_job_id;
      logic [KEY_W-1:0]     removed_key;
      logic                 is_empty;
      logic                 is_full;
      logic [OCC_W-1:0]     occupancy;
   } queue_outcome_type;

   typedef enum logic {
      ROW_JOB  = 1'b0,
      ROW_MODE = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      sjhq_pkg::mode_type mode;
      sjhq_pkg::op_type   op;
      logic [ID_W-1:0]    id;
      logic [KEY_W-1:0]   key;
      int                 reps;
      bit                 typed;
      queue_outcome_type  outcome;
   } stim_row_type;

   localparam queue_outcome_type UNTYPED   =
      '{sjhq_pkg::STATUS_DONE, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 5'd0};
   localparam queue_outcome_type EMPTY_OUT =
      '{sjhq_pkg::STATUS_EMPTY, 1'b0, 16'h0, 16'h0, 1'b1, 1'b0, 5'd0};
   localparam queue_outcome_type FULL_OUT  =
      '{sjhq_pkg::STATUS_FULL, 1'b0, 16'h0, 16'h0, 1'b0, 1'b1, 5'd16};

   localparam int DIRECTED_ROWS = 14;
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF, 1,  1'b1,
        EMPTY_OUT},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 1,  1'b1,
        '{sjhq_pkg::STATUS_DONE, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 5'd1}},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1,  1'b1,
        '{sjhq_pkg::STATUS_DONE, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0, 5'd2}},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1,  1'b1,
        '{sjhq_pkg::STATUS_DONE, 1'b1, 16'h0, 16'h0, 1'b0, 1'b0, 5'd1}},
      // equal keys: the later job goes ahead
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h1234, 16'h8000, 1,  1'b0,
        UNTYPED},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h5678, 16'h8000, 1,  1'b0,
        UNTYPED},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_REMOVE, 16'hAAAA, 16'h5555, 3,  1'b0,
        UNTYPED},
      '{ROW_MODE, sjhq_pkg::MODE_FIFO,   sjhq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1,  1'b0,
        UNTYPED},
      // descending keys, appended in arrival order until full
      '{ROW_JOB,  sjhq_pkg::MODE_FIFO,   sjhq_pkg::OP_INSERT, 16'h0100, 16'hFFFF, 16, 1'b0,
        UNTYPED},
      '{ROW_JOB,  sjhq_pkg::MODE_FIFO,   sjhq_pkg::OP_INSERT, 16'h0200, 16'h0000, 1,  1'b1,
        FULL_OUT},
      '{ROW_JOB,  sjhq_pkg::MODE_FIFO,   sjhq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 1,  1'b0,
        UNTYPED},
      '{ROW_MODE, sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1,  1'b0,
        UNTYPED},
      // sorted insert over entries placed in FIFO order
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h0300, 16'hFFF8, 1,  1'b0,
        UNTYPED},
      '{ROW_JOB,  sjhq_pkg::MODE_SORTED, sjhq_pkg::OP_INSERT, 16'h0400, 16'h0000, 1,  1'b1,
        FULL_OUT}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sjhq_req_if req_ch ();
   sjhq_rsp_if rsp_ch ();

   shortest_job_hold_queue_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the hold queue, head at index 0.
   logic [ID_W-1:0]    shadow_ids  [QUEUE_DEPTH];
   logic [KEY_W-1:0]   shadow_keys [QUEUE_DEPTH];
   int                 shadow_count;
   sjhq_pkg::mode_type shadow_mode;

   queue_outcome_type awaited_outcomes [$];
   int                mismatches;
   int                stalled_cycles;
   bit                idle_sender;
   bit                idle_receiver;
   bit                long_hold_request;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic queue_outcome_type apply_job_item(input sjhq_pkg::op_type op,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [KEY_W-1:0] key);
      queue_outcome_type res;
      int pos;
      res = UNTYPED;
      if (op == sjhq_pkg::OP_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            res.status = sjhq_pkg::STATUS_FULL;
         end else begin
            pos = shadow_count;
            if (shadow_mode == sjhq_pkg::MODE_SORTED) begin
               pos = 0;
               while (pos < shadow_count && shadow_keys[pos] < key) pos++;
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_ids[i]  = shadow_ids[i-1];
               shadow_keys[i] = shadow_keys[i-1];
            end
            shadow_ids[pos]  = id;
            shadow_keys[pos] = key;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         res.status = sjhq_pkg::STATUS_EMPTY;
      end else begin
         res.removed_valid  = 1'b1;
         res.removed_job_id = shadow_ids[0];
         res.removed_key    = shadow_keys[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_ids[i-1]  = shadow_ids[i];
            shadow_keys[i-1] = shadow_keys[i];
         end
         shadow_count--;
      end
      res.is_empty  = (shadow_count == 0);
      res.is_full   = (shadow_count >= QUEUE_DEPTH);
      res.occupancy = OCC_W'(shadow_count);
      return res;
   endfunction

   // Called right after a rising edge; returns at the edge that accepts the item.
   task automatic push_job(input sjhq_pkg::op_type op, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key, input bit typed,
                           input queue_outcome_type typed_outcome);
      int gap;
      queue_outcome_type predicted;
      gap = idle_sender ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.job_id   <= id;
      req_ch.sort_key <= key;
      do @(negedge clock); while (!req_ch.ready);
      predicted = apply_job_item(op, id, key);
      awaited_outcomes.push_back(typed ? typed_outcome : predicted);
      @(posedge clock);
   endtask

   // Drain everything outstanding, then write the mode while the core is idle.
   task automatic write_order_mode(input sjhq_pkg::mode_type mode);
      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_mode = mode;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: random hold-off per result, plus one long hold on request.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_request = 1'b0;
         end
         stall = idle_receiver ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   // Sample mid-cycle: handshakes seen here complete at the next rising edge.
   always @(negedge clock) begin
      queue_outcome_type want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("shortest_job_hold_queue_core: mismatch");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("result with no item outstanding");
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_ch.status));
               check_field("removed_valid", 32'(want.removed_valid),
                           32'(rsp_ch.removed_valid));
               check_field("removed_job_id", 32'(want.removed_job_id),
                           32'(rsp_ch.removed_job_id));
               check_field("removed_key", 32'(want.removed_key), 32'(rsp_ch.removed_key));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
               check_field("is_full", 32'(want.is_full), 32'(rsp_ch.is_full));
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
            end
         end
      end
   end

   initial begin
      int bias;
      bit narrow;
      sjhq_pkg::op_type op;
      logic [KEY_W-1:0] key;
      stim_row_type row;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.op         = sjhq_pkg::OP_INSERT;
      req_ch.job_id     = '0;
      req_ch.sort_key   = '0;
      shadow_count      = 0;
      shadow_mode       = sjhq_pkg::MODE_SORTED;
      mismatches        = 0;
      stalled_cycles    = 0;
      idle_sender       = 1'b1;
      idle_receiver     = 1'b1;
      long_hold_request = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_TABLE[r]) begin
         row = DIRECTED_TABLE[r];
         if (row.kind == ROW_MODE) begin
            write_order_mode(row.mode);
         end else begin
            for (int i = 0; i < row.reps; i++)
               push_job(row.op, row.id + ID_W'(i), row.key - KEY_W'(i), row.typed, row.outcome);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 2)
            write_order_mode(phase == 0 ? sjhq_pkg::MODE_FIFO : sjhq_pkg::MODE_SORTED);
         else
            write_order_mode(($urandom_range(0, 1) != 0) ? sjhq_pkg::MODE_SORTED
                                                         : sjhq_pkg::MODE_FIFO);
         // one phase runs flat out on both sides
         idle_sender   = (phase != 1) && ($urandom_range(0, 3) != 0);
         idle_receiver = (phase != 1) && ($urandom_range(0, 3) != 0);
         // alternate filling and draining so both full and empty are hit often
         bias   = (phase % 2) ? $urandom_range(20, 40) : $urandom_range(60, 80);
         narrow = ($urandom_range(0, 1) != 0);
         if (phase == 3) long_hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op = ($urandom_range(0, 99) < bias) ? sjhq_pkg::OP_INSERT : sjhq_pkg::OP_REMOVE;
            case ($urandom_range(0, 15))
               0:       key = '0;
               1:       key = '1;
               default: key = narrow ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom());
            endcase
            push_job(op, ID_W'($urandom()), key, 1'b0, UNTYPED);
         end
      end

      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("shortest_job_hold_queue_core: match");
      end else begin
         $display("shortest_job_hold_queue_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sjhq_pkg.sv
hdl/sjhq_ifs.sv
hdl/sjhq_cell.sv
hdl/shortest_job_hold_queue_core.sv
bench/shortest_job_hold_queue_core_test.sv
